>>> rtl/tma_pkg.sv
package tma_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [2:0] MODE_IDENT = 3'd0;
	localparam logic [2:0] MODE_LOAD  = 3'd1;
	localparam logic [2:0] MODE_TRANS = 3'd2;
	localparam logic [2:0] MODE_SCALE = 3'd3;
	localparam logic [2:0] MODE_SMUL  = 3'd4;
	localparam logic [2:0] MODE_READ  = 3'd5;

	localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic               saturated;
	} out_item_t;

	// command passed from front to back
	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic               last;
	} cmd_t;

endpackage

>>> rtl/tma_cmd_fifo.sv
module tma_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tma_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output tma_pkg::cmd_t rd_data,
	output logic          empty
);
	import tma_pkg::*;

	// two-entry queue between front and back
	cmd_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en && !full) wptr_q <= ~wptr_q;
			if (rd_en && !empty) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(wr_en && !full) - 2'(rd_en && !empty);
		end
	end
endmodule

>>> rtl/tma_front.sv
module tma_front (
	input  tma_pkg::in_item_t in_item,
	output tma_pkg::cmd_t     cmd
);
	import tma_pkg::*;

	// classify: last is kept only for load beats; unused modes pass through and the back returns zero for them
	always_comb begin
		cmd.mode    = in_item.mode;
		cmd.row     = in_item.row;
		cmd.col     = in_item.col;
		cmd.value_a = in_item.value_a;
		cmd.value_b = in_item.value_b;
		cmd.value_c = in_item.value_c;
		cmd.last    = in_item.last & (in_item.mode == MODE_LOAD);
	end
endmodule

>>> rtl/tma_back.sv
module tma_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tma_pkg::cmd_t      cmd,
	input  logic               cmd_valid,
	output logic               cmd_take,
	output tma_pkg::out_item_t res,
	output logic               res_valid,
	input  logic               res_take
);
	import tma_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic signed [31:0] cur_q [16];
	logic signed [31:0] opd_q [16];
	logic signed [31:0] tmp_q [16];
	cmd_t               cmd_q;
	logic [5:0]         step_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] prod_s1;
	logic               sat_q;
	logic               rv_q;
	out_item_t          res_q;

	// step index: element e = step[5:2], term k = step[1:0]
	logic [3:0]         elem;
	logic [1:0]         kk;
	logic [1:0]         kmax;
	logic signed [31:0] ma, mb;
	logic signed [65:0] acc_nx;
	logic               last_term;
	logic signed [31:0] sat_val;
	logic               sat_hit;

	assign elem = step_q[5:2];
	assign kk   = step_q[1:0];

	// operands for the shared multiplier
	always_comb begin
		ma     = '0;
		mb     = '0;
		kmax   = 2'd0;
		case (cmd_q.mode)
			MODE_LOAD: begin
				ma   = opd_q[{elem[3:2], kk}];
				mb   = cur_q[{kk, elem[1:0]}];
				kmax = 2'd3;
			end
			MODE_TRANS: begin
				kmax = 2'd2;
				mb   = cur_q[{kk, elem[1:0]}];
				case (kk)
					2'd0:    ma = cmd_q.value_a;
					2'd1:    ma = cmd_q.value_b;
					default: ma = cmd_q.value_c;
				endcase
			end
			MODE_SCALE: begin
				mb = cur_q[elem];
				case (elem[3:2])
					2'd0:    ma = cmd_q.value_a;
					2'd1:    ma = cmd_q.value_b;
					default: ma = cmd_q.value_c;
				endcase
			end
			MODE_SMUL: begin
				ma = cmd_q.value_a;
				mb = cur_q[elem];
			end
			default: ;
		endcase
	end

	assign last_term = kk == kmax;
	assign acc_nx    = acc_q + 66'(prod_s1 >>> FRAC_BITS);

	// saturate the finished sum
	always_comb begin
		sat_hit = 1'b0;
		sat_val = acc_nx[31:0];
		if (acc_nx > 66'sd2147483647) begin
			sat_hit = 1'b1;
			sat_val = 32'sh7fffffff;
		end else if (acc_nx < -66'sd2147483648) begin
			sat_hit = 1'b1;
			sat_val = 32'sh80000000;
		end
	end

	assign cmd_take  = state_q == ST_IDLE && cmd_valid && !rv_q;
	assign res_valid = rv_q;
	assign res       = res_q;

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (cmd_take) begin
			cmd_q <= cmd;
			acc_q <= (cmd.mode == MODE_TRANS) ? 66'(cur_q[{2'd3, 2'd0}]) : '0;
			sat_q <= 1'b0;
			if (cmd.mode == MODE_LOAD) opd_q[{cmd.row, cmd.col}] <= cmd.value_a;
		end
		if (state_q == ST_ACC) begin
			if (last_term) begin
				tmp_q[elem] <= sat_val;
				sat_q       <= sat_q | sat_hit;
				acc_q       <= (cmd_q.mode == MODE_TRANS) ?
					66'(cur_q[{2'd3, 2'(elem[1:0] + 2'd1)}]) : '0;
			end else begin
				acc_q <= acc_nx;
			end
		end
		if (state_q == ST_IDLE && cmd_take) begin
			res_q.read_data <= (cmd.mode == MODE_READ) ? cur_q[{cmd.row, cmd.col}] : '0;
			res_q.saturated <= 1'b0;
		end
		if (state_q == ST_DONE) res_q.saturated <= sat_q;
	end

	// current matrix: identity at reset and on an identity command, written at end of an operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				cur_q[i] <= (i % 5 == 0) ? ONE_FX : '0;
		end else if (cmd_take && cmd.mode == MODE_IDENT) begin
			for (int i = 0; i < 16; i++)
				cur_q[i] <= (i % 5 == 0) ? ONE_FX : '0;
		end else if (state_q == ST_DONE) begin
			for (int i = 0; i < 16; i++) begin
				if ((cmd_q.mode == MODE_LOAD && cmd_q.last) || cmd_q.mode == MODE_SMUL ||
					(cmd_q.mode == MODE_SCALE && i < 12) ||
					(cmd_q.mode == MODE_TRANS && i >= 12))
					cur_q[i] <= tmp_q[i];
			end
		end
	end

	// sequencer: issue a product, then accumulate it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (rv_q && res_take) rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if ((cmd.mode == MODE_LOAD && cmd.last) || cmd.mode == MODE_SCALE ||
							cmd.mode == MODE_SMUL) begin
							state_q <= ST_MUL;
							step_q  <= '0;
						end else if (cmd.mode == MODE_TRANS) begin
							state_q <= ST_MUL;
							step_q  <= 6'd48;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (last_term && (elem == 4'd15 ||
						(cmd_q.mode == MODE_SCALE && elem == 4'd11))) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
						step_q  <= last_term ? {4'(elem + 4'd1), 2'd0} : 6'(step_q + 6'd1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rv_q    <= 1'b1;
				end
			endcase
		end
	end
endmodule

>>> rtl/transform_matrix_accumulator_top.sv
// 4x4 transform matrix accumulator, signed fixed point.
// input side is a queue: drive in_item and push while full is low; one beat
// per edge with push high and full low.
// result side is a queue: while empty is low, out_item holds the oldest
// result; pop with empty low takes that beat. one result per input beat.
// a front stage classifies beats into a two-entry command queue; the back
// part executes them on one shared 32x32 multiplier, each term passing
// through a multiply state and then an accumulate state.
// identity, read and a plain load use no multiplier terms; translate runs
// 12 terms, scale 12, scalar multiply 16, and a load marked last 64
// (full premultiply).
// the back holds one finished result; when pop stalls it stops taking
// commands and the queue fills, then full rises. nothing is lost.
// reset loads identity into the current matrix and empties both queues.
module transform_matrix_accumulator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  tma_pkg::in_item_t   in_item,
	input  logic                push,
	output logic                full,
	output tma_pkg::out_item_t  out_item,
	output logic                empty,
	input  logic                pop
);
	import tma_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic q_empty, take, rv;

	tma_front u_front (.in_item(in_item), .cmd(cmd_in));

	tma_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data(cmd_in), .full(full),
		.rd_en(take), .rd_data(cmd_out), .empty(q_empty)
	);

	tma_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_out), .cmd_valid(!q_empty),
		.cmd_take(take), .res(out_item), .res_valid(rv), .res_take(pop)
	);

	assign empty = !rv;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tma_pkg::*;

	localparam int N_RANDOM = 1200;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	in_item_t in_item;
	logic push;
	logic full;
	out_item_t out_item;
	logic empty;
	logic pop;

	transform_matrix_accumulator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.push(push),
		.full(full),
		.out_item(out_item),
		.empty(empty),
		.pop(pop)
	);

	// predicted matrix state
	logic signed [31:0] cur_m [4][4];
	logic signed [31:0] opnd_m [4][4];

	in_item_t pending_q [$];
	out_item_t expected_q [$];
	int n_errors = 0;
	int cycle_cnt;
	bit calm;
	bit hold_send;
	bit hold_done;
	int send_gap;
	int pop_gap;

	// floor-shifted product, full width
	function automatic logic signed [63:0] fx_product(logic signed [31:0] a,
		logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [63:0] v, ref bit clip);
		if (v > 64'sh7FFF_FFFF) begin
			clip = 1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			clip = 1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic void set_identity();
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				cur_m[r][c] = (r == c) ? ONE_FX : 32'sd0;
	endfunction

	// apply one command to the predicted matrix, return the result beat
	function automatic out_item_t apply_transform(in_item_t it);
		out_item_t res;
		bit clip;
		logic signed [31:0] nxt [4][4];
		logic signed [63:0] acc;
		clip = 0;
		res.read_data = '0;
		case (it.mode)
			MODE_IDENT: set_identity();
			MODE_LOAD: begin
				opnd_m[it.row][it.col] = it.value_a;
				if (it.last) begin
					for (int r = 0; r < 4; r++)
						for (int c = 0; c < 4; c++) begin
							acc = 0;
							for (int k = 0; k < 4; k++)
								acc += fx_product(opnd_m[r][k], cur_m[k][c]);
							nxt[r][c] = clip32(acc, clip);
						end
					cur_m = nxt;
				end
			end
			MODE_TRANS: begin
				for (int c = 0; c < 4; c++) begin
					acc = fx_product(it.value_a, cur_m[0][c]) + fx_product(it.value_b, cur_m[1][c])
						+ fx_product(it.value_c, cur_m[2][c]) + 64'(cur_m[3][c]);
					nxt[3][c] = clip32(acc, clip);
				end
				for (int c = 0; c < 4; c++)
					cur_m[3][c] = nxt[3][c];
			end
			MODE_SCALE: begin
				for (int c = 0; c < 4; c++) begin
					cur_m[0][c] = clip32(fx_product(it.value_a, cur_m[0][c]), clip);
					cur_m[1][c] = clip32(fx_product(it.value_b, cur_m[1][c]), clip);
					cur_m[2][c] = clip32(fx_product(it.value_c, cur_m[2][c]), clip);
				end
			end
			MODE_SMUL: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						cur_m[r][c] = clip32(fx_product(it.value_a, cur_m[r][c]), clip);
			end
			MODE_READ: res.read_data = cur_m[it.row][it.col];
			default: ;
		endcase
		res.saturated = clip;
		return res;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return ONE_FX;
			3: return -ONE_FX;
			4: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			5: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t make_item(logic [2:0] mode, logic [1:0] row,
		logic [1:0] col, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c, logic last);
		in_item_t it;
		it.mode = mode;
		it.row = row;
		it.col = col;
		it.value_a = a;
		it.value_b = b;
		it.value_c = c;
		it.last = last;
		return it;
	endfunction

	// full operand matrix, the final element marked last; keeps operand defined
	task automatic add_operand_matrix(bit near_ident);
		logic signed [31:0] v;
		for (int i = 0; i < 16; i++) begin
			if (near_ident)
				v = (i[1:0] == i[3:2]) ? ONE_FX + $signed($urandom_range(0, 4095)) - 2048
					: $signed($urandom_range(0, 8191)) - 4096;
			else
				v = rand_value();
			pending_q.push_back(make_item(MODE_LOAD, i[3:2], i[1:0], v, $urandom,
				$urandom, i == 15));
		end
	endtask

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// stimulus list
	initial begin
		logic [2:0] m;
		logic [1:0] rr;
		logic [1:0] cc;
		arst_n = 0;
		// directed: identity, reads, extremes, every mode, unused modes
		pending_q.push_back(make_item(MODE_READ, 2'd0, 2'd0, 0, 0, 0, 0));
		pending_q.push_back(make_item(MODE_READ, 2'd3, 2'd2, 0, 0, 0, 0));
		pending_q.push_back(make_item(MODE_TRANS, 2'd3, 2'd3, 32'sh0003_8000,
			-32'sh0001_0000, 32'sh7FFF_FFFF, 1));
		pending_q.push_back(make_item(MODE_READ, 2'd3, 2'd2, 0, 0, 0, 0));
		pending_q.push_back(make_item(MODE_SCALE, 2'd1, 2'd1, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh0000_8000, 0));
		pending_q.push_back(make_item(MODE_SMUL, 2'd0, 2'd0, 32'sh7FFF_FFFF, 0, 0, 1));
		pending_q.push_back(make_item(MODE_READ, 2'd1, 2'd1, 0, 0, 0, 0));
		pending_q.push_back(make_item(3'd6, 2'd3, 2'd3, '1, '1, '1, 1));
		pending_q.push_back(make_item(3'd7, 2'd0, 2'd0, 0, 0, 0, 0));
		pending_q.push_back(make_item(MODE_IDENT, 2'd2, 2'd1, '1, '1, '1, 1));
		pending_q.push_back(make_item(MODE_SMUL, 2'd0, 2'd0, -32'sh0000_0001, 0, 0, 0));
		pending_q.push_back(make_item(MODE_READ, 2'd0, 2'd0, 0, 0, 0, 0));
		pending_q.push_back(make_item(MODE_IDENT, 0, 0, 0, 0, 0, 0));
		add_operand_matrix(0);
		// random: mostly well-formed transform sequences
		while (pending_q.size() < N_RANDOM) begin
			rr = 2'($urandom);
			cc = 2'($urandom);
			case ($urandom_range(0, 19))
				0, 1: pending_q.push_back(make_item(MODE_IDENT, rr, cc, $urandom,
					$urandom, $urandom, 1'($urandom)));
				2, 3: add_operand_matrix($urandom_range(0, 3) != 0);
				4, 5, 6: pending_q.push_back(make_item(MODE_LOAD, rr, cc, rand_value(),
					$urandom, $urandom, $urandom_range(0, 3) == 0));
				7, 8: pending_q.push_back(make_item(MODE_TRANS, rr, cc, rand_value(),
					rand_value(), rand_value(), 1'($urandom)));
				9, 10: pending_q.push_back(make_item(MODE_SCALE, rr, cc, rand_value(),
					rand_value(), rand_value(), 1'($urandom)));
				11: pending_q.push_back(make_item(MODE_SMUL, rr, cc, rand_value(),
					$urandom, $urandom, 1'($urandom)));
				12: begin
					m = 3'($urandom_range(6, 7));
					pending_q.push_back(make_item(m, rr, cc, $urandom, $urandom,
						$urandom, 1'($urandom)));
				end
				default: pending_q.push_back(make_item(MODE_READ, rr, cc, $urandom,
					$urandom, $urandom, 1'($urandom)));
			endcase
		end
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// load beats may only use operand slots already written before last
	// (add_operand_matrix ends the directed part, before any random load, so all are defined)

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			in_item <= '0;
			send_gap <= 0;
			hold_send <= 0;
			hold_done <= 0;
			set_identity();
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					opnd_m[r][c] = '0;
		end else begin
			if (push && !full) begin
				expected_q.push_back(apply_transform(in_item));
			end
			if (push && full) begin
				// keep presenting the same beat
			end else if (hold_send) begin
				push <= 0;
				if (expected_q.size() == 0 && !(push && !full))
					hold_send <= 0;
			end else if (send_gap > 0) begin
				push <= 0;
				send_gap <= send_gap - 1;
			end else if (pending_q.size() == 0) begin
				push <= 0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				push <= 0;
				send_gap <= $urandom_range(0, 8);
			end else if (!hold_done && pending_q.size() <= N_RANDOM / 2) begin
				// wait here until every expected result has come back
				push <= 0;
				hold_send <= 1;
				hold_done <= 1;
			end else begin
				push <= 1;
				in_item <= pending_q.pop_front();
			end
		end
	end

	// monitor and result-side stall
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pop <= 0;
			pop_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result beat read_data=%0h", out_item.read_data);
					n_errors++;
				end else begin
					want = expected_q.pop_front();
					if (out_item.read_data !== want.read_data) begin
						$error("read_data expected %0h actual %0h", want.read_data,
							out_item.read_data);
						n_errors++;
					end
					if (out_item.saturated !== want.saturated) begin
						$error("saturated expected %0b actual %0b", want.saturated,
							out_item.saturated);
						n_errors++;
					end
				end
			end
			if (pop_gap > 0) begin
				pop <= 0;
				pop_gap <= pop_gap - 1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				pop <= 0;
				pop_gap <= $urandom_range(0, 8);
			end else begin
				pop <= 1;
			end
		end
	end

	// run control and timeout
	initial begin
		cycle_cnt = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (pending_q.size() < 150)
				calm = 1;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
			if (arst_n && pending_q.size() == 0 && !push && expected_q.size() == 0) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				if (n_errors == 0 && expected_q.size() == 0)
					$display("TB_OK");
				else
					$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
